@@ hdl/ookpw_pkg.sv @@
// ----------------------------------------------------------------------------
// ookpw_pkg
// Shared types and timing constants for the OOK pulse width receiver.
// ----------------------------------------------------------------------------
package ookpw_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd1,
        PH_START = 3'd2,
        PH_GAP   = 3'd3,
        PH_FIRST = 3'd4,
        PH_LOW   = 3'd5,
        PH_HIGH  = 3'd6,
        PH_CLOSE = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        REG_LOCKOUT  = 2'd0,
        REG_MIN_BITS = 2'd1,
        REG_MAX_BITS = 2'd2
    } reg_idx_t;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // pulse widths in microseconds
    localparam logic [31:0] SHORT_MIN = 32'd250;
    localparam logic [31:0] SHORT_MAX = 32'd600;
    localparam logic [31:0] LONG_MIN  = 32'd800;
    localparam logic [31:0] LONG_MAX  = 32'd1600;
    localparam logic [31:0] GAP_MIN   = 32'd4000;
    localparam logic [31:0] GAP_MAX   = 32'd17000;

    // packet lengths that are realigned by two bits
    localparam logic [5:0] LEN_ALIGN_A = 6'd18;
    localparam logic [5:0] LEN_ALIGN_B = 6'd19;

    localparam logic [31:0] LOCKOUT_RST  = 32'd600000;
    localparam logic [5:0]  MIN_BITS_RST = 6'd12;
    localparam logic [5:0]  MAX_BITS_RST = 6'd32;

    typedef struct packed {
        logic [31:0] lockout_us;
        logic [5:0]  min_bits;
        logic [5:0]  max_bits;
    } cfg_t;

    typedef struct packed {
        logic        packet_valid;
        logic [31:0] packet;
        logic [5:0]  bit_count;
    } result_t;

endpackage

@@ hdl/ookpw_decoder.sv @@
// ----------------------------------------------------------------------------
// ookpw_decoder
// Pulse width state machine, packet assembly, lockout and holding register.
// ----------------------------------------------------------------------------
module ookpw_decoder #(
    parameter int PACKET_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              fetch,
    input  logic              level,
    input  logic [31:0]       time_us,
    input  ookpw_pkg::cfg_t    cfg,
    output ookpw_pkg::result_t result
);
    import ookpw_pkg::*;

    localparam logic [4:0] TOP_POS = 5'(PACKET_BITS - 1);

    phase_t      phase_reg, phase_next;
    logic [31:0] shift_reg, shift_next;
    logic [4:0]  pos_reg, pos_next;
    logic [5:0]  seen_reg, seen_next;
    logic [31:0] rise_reg, rise_next;
    logic [31:0] fall_reg, fall_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] accept_reg, accept_next;
    logic [31:0] hold_reg, hold_next;
    logic        full_reg, full_next;
    logic [5:0]  dcount_reg, dcount_next;

    function automatic logic in_range(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            shift_reg  <= '0;
            pos_reg    <= TOP_POS;
            seen_reg   <= '0;
            rise_reg   <= '0;
            fall_reg   <= '0;
            prev_reg   <= '0;
            accept_reg <= '0;
            hold_reg   <= '0;
            full_reg   <= 1'b0;
            dcount_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            pos_reg    <= pos_next;
            seen_reg   <= seen_next;
            rise_reg   <= rise_next;
            fall_reg   <= fall_next;
            prev_reg   <= prev_next;
            accept_reg <= accept_next;
            hold_reg   <= hold_next;
            full_reg   <= full_next;
            dcount_reg <= dcount_next;
        end
    end

    always_comb
    begin
        logic [31:0] high_w;
        logic [31:0] low_w;
        logic [31:0] pkt;
        logic        is_zero;
        logic        is_one;
        logic        store;
        logic [4:0]  pos_dec;

        phase_next  = phase_reg;
        shift_next  = shift_reg;
        pos_next    = pos_reg;
        seen_next   = seen_reg;
        rise_next   = rise_reg;
        fall_next   = fall_reg;
        prev_next   = prev_reg;
        accept_next = accept_reg;
        hold_next   = hold_reg;
        full_next   = full_reg;
        dcount_next = dcount_reg;

        high_w  = '0;
        low_w   = '0;
        pkt     = shift_reg;
        is_zero = 1'b0;
        is_one  = 1'b0;
        store   = 1'b0;
        pos_dec = pos_reg - 5'd1;

        if (step && fetch)
        begin
            full_next = 1'b0;
        end
        else if (step)
        begin
            if (level)
                rise_next = time_us;
            else
                fall_next = time_us;
            high_w  = time_us - rise_next;
            low_w   = time_us - fall_next;
            is_zero = in_range(high_w, SHORT_MIN, SHORT_MAX);
            is_one  = in_range(high_w, LONG_MIN, LONG_MAX);

            case (phase_reg)
                PH_IDLE:
                begin
                    pos_next   = TOP_POS;
                    shift_next = '0;
                    phase_next = level ? PH_START : PH_GAP;
                end
                PH_START:
                    phase_next = is_zero ? PH_GAP : PH_IDLE;
                PH_GAP:
                    phase_next = in_range(low_w, GAP_MIN, GAP_MAX) ? PH_FIRST : PH_IDLE;
                PH_FIRST:
                begin
                    pos_next   = TOP_POS;
                    shift_next = is_one ? (32'd1 << TOP_POS) : '0;
                    if (is_zero || is_one)
                    begin
                        seen_next  = 6'd1;
                        phase_next = PH_LOW;
                    end
                    else
                    begin
                        seen_next  = '0;
                        phase_next = PH_IDLE;
                    end
                end
                PH_LOW:
                begin
                    if (in_range(low_w, SHORT_MIN, LONG_MAX))
                        phase_next = PH_HIGH;
                    else if (in_range(low_w, GAP_MIN, GAP_MAX))
                    begin
                        if (seen_reg >= cfg.min_bits || pos_reg == '0
                            || seen_reg >= cfg.max_bits)
                            phase_next = PH_CLOSE;
                        else
                            phase_next = PH_FIRST;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                PH_HIGH:
                begin
                    if (is_zero || is_one)
                    begin
                        pos_next  = pos_dec;
                        seen_next = seen_reg + 6'd1;
                        if (is_one)
                            shift_next = shift_reg | (32'd1 << pos_dec);
                        else
                            shift_next = shift_reg & ~(32'd1 << pos_dec);
                        phase_next = (pos_dec == '0 || seen_next >= cfg.max_bits)
                                     ? PH_CLOSE : PH_LOW;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                PH_CLOSE:
                begin
                    if (seen_reg >= cfg.min_bits)
                    begin
                        if (seen_reg inside {LEN_ALIGN_A, LEN_ALIGN_B})
                            pkt = shift_reg >> 2;
                        shift_next  = pkt;
                        accept_next = time_us;
                        // identical repeat must clear the lockout window
                        if (prev_reg == pkt)
                            store = (time_us - accept_reg) >= cfg.lockout_us;
                        else
                            store = 1'b1;
                        if (store && !full_reg)
                        begin
                            hold_next   = pkt;
                            full_next   = 1'b1;
                            dcount_next = seen_reg;
                        end
                        prev_next  = pkt;
                        phase_next = in_range(low_w, GAP_MIN, GAP_MAX) ? PH_FIRST : PH_IDLE;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    assign result.packet_valid = full_reg;
    assign result.packet       = full_reg ? hold_reg : '0;
    assign result.bit_count    = dcount_reg;

`ifndef SYNTHESIS
    a_low_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LOW || phase_reg == PH_HIGH) |-> seen_reg != '0)
        else $error("bit phase with no bits seen");
    a_full_clears_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(full_reg) |-> $past(step && fetch))
        else $error("holding register emptied without fetch");
    a_fill_from_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full_reg) |-> $past(step && !fetch && phase_reg == PH_CLOSE))
        else $error("holding register filled outside packet close");
`endif

endmodule

@@ hdl/ook_pulse_width_receiver.sv @@
// ----------------------------------------------------------------------------
// ook_pulse_width_receiver
// On-off-keyed packet receiver driven by timestamped pin edge words.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  s_axis    in   tvalid/tready     tuser: opcode; tdata: level, time_us
//  m_axis    out  tvalid/tready     tuser: packet_valid; tdata: packet, bit_count
//  apb       in   psel/penable      lockout_us @0x0, min_bits @0x4, max_bits @0x8
//
//  One word per cycle while no fetch stalls: input register, one pass through the decoder, output reg.
//  Edge words produce no result; a fetch word gives one result via the input and output registers.
//  A fetch stalls in the input register only while the output register is full
//  and not taken; edge words never stall.
//  Reset is asynchronous; state, flags and config go to defaults at once; data regs are not reset.
// ----------------------------------------------------------------------------
module ook_pulse_width_receiver #(
    parameter int PACKET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [0] level, [32:1] time_us, rest zero
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] packet, [37:32] bit_count, rest zero
    output logic [0:0]  m_axis_tuser,   // [0] packet_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ookpw_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        in_op_reg;
    logic        in_level_reg;
    logic [31:0] in_time_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     dec_result;
    logic        advance;
    logic        out_free;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_us <= LOCKOUT_RST;
            cfg_reg.min_bits   <= MIN_BITS_RST;
            cfg_reg.max_bits   <= MAX_BITS_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_LOCKOUT:  cfg_reg.lockout_us <= pwdata;
                REG_MIN_BITS: cfg_reg.min_bits   <= pwdata[5:0];
                REG_MAX_BITS: cfg_reg.max_bits   <= pwdata[5:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_LOCKOUT:  prdata = cfg_reg.lockout_us;
            REG_MIN_BITS: prdata = {26'd0, cfg_reg.min_bits};
            REG_MAX_BITS: prdata = {26'd0, cfg_reg.max_bits};
            default:      prdata = '0;
        endcase
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (in_op_reg == OP_EDGE || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg    <= s_axis_tuser[0];
            in_level_reg <= s_axis_tdata[0];
            in_time_reg  <= s_axis_tdata[32:1];
        end
    end

    ookpw_decoder #(
        .PACKET_BITS (PACKET_BITS)
    ) u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .fetch   (in_op_reg == OP_FETCH),
        .level   (in_level_reg),
        .time_us (in_time_reg),
        .cfg     (cfg_reg),
        .result  (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_op_reg == OP_FETCH)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_op_reg == OP_FETCH)
            out_reg <= dec_result;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_reg.packet_valid;
    assign m_axis_tdata    = {2'd0, out_reg.bit_count, out_reg.packet};

`ifndef SYNTHESIS
    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tdata[31:0] == '0)
        else $error("empty fetch result carries packet bits");
    a_fetch_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_time_reg)))
        else $error("stalled fetch word lost");
    a_edge_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_op_reg == OP_EDGE) |-> advance)
        else $error("edge word stalled");
`endif

endmodule
